>>> design/selsf_pkg.sv
// Shared constants, types and helpers for the selectable smoothing filter.
`default_nettype none

package selsf_pkg;

  // Sample and window geometry
  localparam int SAMPLE_W = 16;
  localparam int WINDOW   = 16;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + SLOT_W;

  // Exponential filter fixed point
  localparam int FRAC_W  = 15;
  localparam int STATE_W = SAMPLE_W + FRAC_W;
  localparam int ALPHA_W = 16;
  localparam int ALPHA_IW = $clog2(ALPHA_W);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << FRAC_W);

  // Shared adder width: difference times alpha
  localparam int ALU_W = STATE_W + 1 + ALPHA_W;

  // Divider: dividend is |sum| plus half the count
  localparam int DIV_W = SUM_W;
  localparam int CNT_W = $clog2((DIV_W > ALPHA_W) ? DIV_W : ALPHA_W);

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ALPHA_W;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = CFG_IDX_W'(1);
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(16384);

  localparam logic signed [ALU_W-1:0] HALF_Q  = ALU_W'(1 << (FRAC_W - 1));
  localparam logic signed [ALU_W-1:0] SMP_MAX = ALU_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ALU_W-1:0] SMP_MIN = ~SMP_MAX;

  // Request to the shared add/subtract unit
  typedef struct packed {
    logic                    sub;
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
  } alu_req_t;

  // Saturate a wide value to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ALU_W-1:0] v);
    logic signed [ALU_W-1:0] c;
    begin
      if (v > SMP_MAX) begin
        c = SMP_MAX;
      end else if (v < SMP_MIN) begin
        c = SMP_MIN;
      end else begin
        c = v;
      end
      return c[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/selsf_alu.sv
// Shared add/subtract unit used for every arithmetic step of the filter.
`default_nettype none

module selsf_alu (
  input  selsf_pkg::alu_req_t                    req,
  output logic signed [selsf_pkg::ALU_W-1:0]     res
);
  import selsf_pkg::*;

  // One wide adder, operand b inverted for subtraction
  always_comb begin
    if (req.sub) begin
      res = req.a - req.b;
    end else begin
      res = req.a + req.b;
    end
  end

endmodule

`default_nettype wire

>>> design/selsf_hist.sv
// Moving-average history store: one shared address, registered read.
`default_nettype none

module selsf_hist (
  input  logic                                 clk,
  input  logic [selsf_pkg::SLOT_W-1:0]         addr,
  input  logic                                 wr_en,
  input  logic signed [selsf_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [selsf_pkg::SAMPLE_W-1:0] rd_data
);
  import selsf_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
  end

endmodule

`default_nettype wire

>>> design/selectable_smoothing_filter.sv
// Mode 1 runs the divide in place of the rounding step of mode 0, and a first sample
// skips the multiply; in_ready rises with out_valid.
// One item is in work at a time; the longest steps are the 16-step shift-add multiply
// and the 20-step restoring divide, both run on the one shared adder.
// A finished result waits in the output register while the next beat is taken.
// Synchronous reset: mode 0, alpha 0.5, empty window, zero filter state.
`default_nettype none

module selectable_smoothing_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [selsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [selsf_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [selsf_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                   first,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [selsf_pkg::SAMPLE_W-1:0]  filtered
);
  import selsf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DIFF  = 12'b0000_0000_0010,
    S_MUL   = 12'b0000_0000_0100,
    S_PUPD  = 12'b0000_0000_1000,
    S_SUM1  = 12'b0000_0001_0000,
    S_SUM2  = 12'b0000_0010_0000,
    S_ROUND = 12'b0000_0100_0000,
    S_ABS   = 12'b0000_1000_0000,
    S_BIAS  = 12'b0001_0000_0000,
    S_DIV   = 12'b0010_0000_0000,
    S_NEG   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic               mode;
  logic [ALPHA_W-1:0] alpha;

  // Latched beat
  logic signed [SAMPLE_W-1:0] x;
  logic                       first_r;
  logic                       mode_r;
  logic [ALPHA_W-1:0]         a_sat;

  // Filter state
  logic signed [STATE_W-1:0] prev;
  logic [SLOT_W-1:0]         slot;
  logic [FILL_W-1:0]         fill;
  logic signed [SUM_W-1:0]   wsum;

  // Working registers
  logic signed [ALU_W-1:0]    acc;
  logic signed [ALU_W-1:0]    dsh;
  logic [CNT_W-1:0]           cnt;
  logic [DIV_W-1:0]           quo;
  logic [FILL_W-1:0]          rem;
  logic signed [SAMPLE_W-1:0] outcome;

  alu_req_t                   alu_req;
  logic signed [ALU_W-1:0]    alu_res;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic                       hist_we;
  logic [FILL_W:0]            trial;
  logic                       out_free;

  selsf_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  selsf_hist u_hist (
    .clk     (clk),
    .addr    (slot),
    .wr_en   (hist_we),
    .wr_data (x),
    .rd_data (hist_rd)
  );

  assign in_ready = (state == S_IDLE);
  assign hist_we  = (state == S_SUM2);
  assign trial    = {rem, quo[DIV_W-1]};
  assign out_free = !out_valid || out_ready;

  // Operand selection for the shared adder
  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      S_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(x) <<< FRAC_W;
        alu_req.b   = first_r ? '0 : ALU_W'(prev);
      end
      S_MUL: begin
        alu_req.a = acc;
        alu_req.b = a_sat[cnt[ALPHA_IW-1:0]] ? dsh : '0;
      end
      S_PUPD: begin
        alu_req.a = ALU_W'(prev);
        alu_req.b = acc >>> FRAC_W;
      end
      S_SUM1: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(wsum);
        alu_req.b   = ALU_W'(hist_rd);
      end
      S_SUM2: begin
        alu_req.a = ALU_W'(wsum);
        alu_req.b = ALU_W'(x);
      end
      S_ROUND: begin
        alu_req.a = ALU_W'(prev);
        alu_req.b = HALF_Q;
      end
      S_ABS: begin
        alu_req.sub = wsum[SUM_W-1];
        alu_req.b   = ALU_W'(wsum);
      end
      S_BIAS: begin
        alu_req.a = ALU_W'(quo);
        alu_req.b = ALU_W'(fill >> 1);
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(trial);
        alu_req.b   = ALU_W'(fill);
      end
      S_NEG: begin
        alu_req.sub = wsum[SUM_W-1];
        alu_req.b   = ALU_W'(quo);
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      alpha <= ALPHA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:  mode  <= cfg_data[0];
        REG_ALPHA: alpha <= cfg_data[ALPHA_W-1:0];
        default:   mode  <= mode;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      prev      <= '0;
      slot      <= '0;
      fill      <= '0;
      wsum      <= '0;
      cnt       <= '0;
    end else begin
      // S_OUT refills the output register itself
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (first) begin
              slot <= '0;
              fill <= '0;
              wsum <= '0;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          cnt <= '0;
          if (first_r) begin
            prev  <= alu_res[STATE_W-1:0];
            state <= S_SUM1;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ALPHA_W - 1)) begin
            state <= S_PUPD;
          end
        end
        S_PUPD: begin
          prev  <= alu_res[STATE_W-1:0];
          state <= S_SUM1;
        end
        S_SUM1: begin
          if (fill == FILL_W'(WINDOW)) begin
            wsum <= alu_res[SUM_W-1:0];
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_SUM2;
        end
        S_SUM2: begin
          wsum  <= alu_res[SUM_W-1:0];
          slot  <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          state <= mode_r ? S_ABS : S_ROUND;
        end
        S_ROUND: begin
          state <= S_OUT;
        end
        S_ABS: begin
          state <= S_BIAS;
        end
        S_BIAS: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_W - 1)) begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x       <= sample;
        first_r <= first;
        mode_r  <= mode;
        a_sat   <= (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      end
      S_DIFF: begin
        dsh <= alu_res;
        acc <= HALF_Q;
      end
      S_MUL: begin
        acc <= alu_res;
        dsh <= dsh <<< 1;
      end
      S_ROUND: begin
        outcome <= sat_sample(alu_res >>> FRAC_W);
      end
      S_ABS: begin
        quo <= alu_res[DIV_W-1:0];
      end
      S_BIAS: begin
        quo <= alu_res[DIV_W-1:0];
        rem <= '0;
      end
      // Restoring divide: keep the trial difference when it does not go negative
      S_DIV: begin
        if (!alu_res[ALU_W-1]) begin
          rem <= alu_res[FILL_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= trial[FILL_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
      end
      S_NEG: begin
        outcome <= sat_sample(alu_res);
      end
      S_OUT: begin
        if (out_free) begin
          filtered <= outcome;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/selsf_checker.sv
// Port-level checks for the smoothing filter, bound to the top level.
`default_nettype none

module selsf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [selsf_pkg::SAMPLE_W-1:0]  filtered
);
  import selsf_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("result beat dropped or changed while stalled");

  // Busy once a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a beat");

  // A result appears only at the end of a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without work in progress");

  // Reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind selectable_smoothing_filter selsf_checker u_selsf_checker (.*);

`default_nettype wire

>>> test/smoothing_checker.sv
// Checker for the selectable smoothing filter: tracks filter state and scores every output beat.
`timescale 1ns / 100ps

module smoothing_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [selsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [selsf_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [selsf_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                   first,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [selsf_pkg::SAMPLE_W-1:0]  filtered,
  output int                                     errors,
  output int                                     pending,
  output int                                     checked
);
  import selsf_pkg::*;

  localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);

  // Shadow registers
  logic                       mode_q;
  logic [ALPHA_W-1:0]         alpha_q;

  // Shadow filter state
  logic signed [SAMPLE_W-1:0] window_hist [WINDOW];
  logic [SLOT_W-1:0]          slot_q;
  logic [FILL_W-1:0]          fill_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [STATE_W-1:0]  ema_q;

  // Results still owed by the block, oldest first
  logic signed [SAMPLE_W-1:0] filtered_due [$];
  logic signed [SAMPLE_W-1:0] want;

  function automatic logic signed [SAMPLE_W-1:0] to_sample(input longint v);
    longint hi;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < -hi - 1) begin
      return SAMPLE_W'(-hi - 1);
    end
    return SAMPLE_W'(v);
  endfunction

  // Advance both histories by one sample and return what the selected mode gives
  function automatic logic signed [SAMPLE_W-1:0] predict_filtered(
    input logic signed [SAMPLE_W-1:0] x,
    input logic                       start
  );
    longint weight, diff, prod, mag, quot;
    logic signed [SAMPLE_W-1:0] ema_out, avg_out;
    weight = (alpha_q > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q);

    // exponential: state in Q15, step rounded half up
    if (start) begin
      ema_q = STATE_W'(longint'(x) <<< FRAC_W);
    end else begin
      diff  = (longint'(x) <<< FRAC_W) - longint'(ema_q);
      prod  = weight * diff;
      ema_q = STATE_W'(longint'(ema_q) + ((prod + HALF_LSB) >>> FRAC_W));
    end
    ema_out = to_sample((longint'(ema_q) + HALF_LSB) >>> FRAC_W);

    // moving average over the record's last samples
    if (start) begin
      slot_q = '0;
      fill_q = '0;
      sum_q  = '0;
    end
    if (fill_q == WINDOW) begin
      sum_q = sum_q - window_hist[slot_q];
    end else begin
      fill_q = fill_q + 1'b1;
    end
    window_hist[slot_q] = x;
    sum_q  = sum_q + x;
    slot_q = slot_q + 1'b1;

    // divide with rounding half away from zero
    mag  = (sum_q < 0) ? -longint'(sum_q) : longint'(sum_q);
    quot = (mag + longint'(fill_q / 2)) / longint'(fill_q);
    avg_out = to_sample((sum_q < 0) ? -quot : quot);

    return mode_q ? avg_out : ema_out;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_q  = 1'b0;
      alpha_q = ALPHA_RESET;
      slot_q  = '0;
      fill_q  = '0;
      sum_q   = '0;
      ema_q   = '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MODE) begin
          mode_q = cfg_data[0];
        end else if (cfg_index == REG_ALPHA) begin
          alpha_q = cfg_data[ALPHA_W-1:0];
        end
      end

      // output beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (filtered_due.size() == 0) begin
          errors++;
          $display("%0t: output beat %0d with no result outstanding", $time, filtered);
        end else begin
          want = filtered_due.pop_front();
          pending--;
          checked++;
          if (filtered !== want) begin
            errors++;
            $display("%0t: filtered mismatch: expected %0d, actual %0d",
                     $time, want, filtered);
          end
        end
      end

      // input beat: predict its result
      if (in_valid && in_ready) begin
        filtered_due.push_back(predict_filtered(sample, first));
        pending++;
      end
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the selectable smoothing filter: drives beats and register writes.
`timescale 1ns / 100ps

module tb_top;
  import selsf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 155;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] filtered;

  int errors, pending, checked;
  int send_idle_pct  = 16;
  int recv_stall_pct = 70;
  int cycles     = 0;
  int beats_sent = 0;
  int cfg_writes = 0;
  int records    = 0;

  selectable_smoothing_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
  );

  smoothing_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit, %0d results outstanding", $time, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input beat; valid is left high after acceptance so back-to-back beats stay clean
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] value, input logic start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = value;
    first    = start;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Hold off until every outstanding result has been taken
  task automatic wait_results_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_results_done();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_writes++;
  endtask

  task automatic random_cfg();
    logic [CFG_W-1:0] a;
    case ($urandom_range(7))
      0:       a = 16'd0;
      1:       a = 16'd1;
      2:       a = 16'd32767;
      3:       a = 16'd32768;
      4:       a = 16'hFFFF;
      5:       a = CFG_W'($urandom_range(32769, 65534));
      default: a = CFG_W'($urandom_range(32768));
    endcase
    write_reg(REG_MODE, CFG_W'($urandom_range(1)));
    write_reg(REG_ALPHA, a);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
      3:       return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    int len;
    logic start;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
    first     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // exponential mode from reset, no record start yet
    send_beat(16'sd100, 1'b0);
    send_beat(-16'sd3, 1'b0);
    send_beat(16'sh7FFF, 1'b1);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sd1, 1'b0);
    send_beat(-16'sd1, 1'b0);

    // moving average: continuing window, ties both signs, extremes
    write_reg(REG_MODE, 16'd1);
    send_beat(16'sd5, 1'b0);
    send_beat(16'sd1, 1'b1);
    send_beat(16'sd2, 1'b0);
    send_beat(-16'sd1, 1'b1);
    send_beat(-16'sd2, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b1);
    send_beat(16'sh8000, 1'b0);

    // exponential with alpha at zero, one, above one and the smallest step
    write_reg(REG_MODE, 16'd0);
    write_reg(REG_ALPHA, 16'd0);
    send_beat(16'sd7, 1'b1);
    send_beat(16'sh8000, 1'b0);
    write_reg(REG_ALPHA, 16'd32768);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    write_reg(REG_ALPHA, 16'hFFFF);
    send_beat(16'sd123, 1'b0);
    send_beat(-16'sd5, 1'b0);
    write_reg(REG_ALPHA, 16'd1);
    send_beat(16'sh7FFF, 1'b1);
    send_beat(16'sh8000, 1'b0);

    // random records under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 16 : (ph == 1) ? 70 : 0;
      recv_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 16 : 0;
      random_cfg();
      for (int n = 0; n < PHASE_BEATS; n += len) begin
        len   = ($urandom_range(3) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
        // mostly proper records; some carry on without a start flag
        start = ($urandom_range(7) != 0);
        for (int k = 0; k < len; k++) begin
          send_beat(rand_sample(), start && (k == 0));
        end
        records++;
        if ($urandom_range(5) == 0) begin
          random_cfg();
        end else if ($urandom_range(19) == 0) begin
          wait_results_done();
        end
      end
    end

    // drain and settle
    wait_results_done();
    repeat (60) @(posedge clk);

    $display("Covered %0d sample beats over %0d random records, %0d results checked, %0d writes;",
             beats_sent, records, checked, cfg_writes);
    $display("both modes, alpha from zero to saturation, three stall patterns.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
